FILE: design/i2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer-to-ASCII formatter
// Sizes, conversion kind codes, controller states, datapath command/status.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_W      = 64;
  localparam int DIGIT_DEPTH  = 64;
  localparam int DADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int MAX_WIDTH    = 64;
  localparam int CNT_W        = 7;
  localparam int SPACE_W      = 8;
  localparam int BCD_DIGITS   = 20;
  localparam int MAG_W        = 4 * BCD_DIGITS;
  localparam int DABBLE_STEPS = VALUE_W;
  localparam int STEP_W       = $clog2(DABBLE_STEPS);

  // Conversion kinds
  localparam logic [2:0] KIND_BIN  = 3'd0;
  localparam logic [2:0] KIND_SDEC = 3'd1;
  localparam logic [2:0] KIND_UDEC = 3'd2;
  localparam logic [2:0] KIND_OCT  = 3'd3;
  localparam logic [2:0] KIND_HEXL = 3'd4;
  localparam logic [2:0] KIND_HEXU = 3'd5;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_MOVE,
    ST_EXTRACT,
    ST_SETUP,
    ST_SIGN_PRE,
    ST_PAD,
    ST_SIGN_POST,
    ST_DIGITS
  } state_t;

  typedef enum logic [1:0] {
    CH_MINUS,
    CH_PAD,
    CH_DIGIT
  } char_sel_t;

  typedef struct packed {
    logic      load;      // take the input word
    logic      dabble;    // one binary-to-BCD shift step
    logic      bcd_move;  // move BCD result into the magnitude register
    logic      extract;   // store one digit, shift magnitude
    logic      setup;     // compute pad count, fetch top digit
    logic      emit;      // load one character into the output register
    char_sel_t sel;       // which character to emit
  } dp_cmd_t;

  typedef struct packed {
    logic in_kind_ok;
    logic in_is_dec;
    logic dabble_last;
    logic mag_last;
    logic neg;
    logic zp;
    logic pad_zero;
    logic dcnt_one;
    logic space_zero;
    logic out_free;
  } dp_stat_t;

  // Map a digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CHAR_ZERO + {4'd0, d};
    end else if (upper) begin
      ch = CHAR_UP_A + {4'd0, d} - 8'd10;
    end else begin
      ch = CHAR_LOW_A + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: design/integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: printf-style integer to ASCII conversion
// Binary, decimal, octal and hex with minimum width and space or zero padding.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  kind, value, min_width, zero_pad, space_left
//   out      out_valid/out_stall  char_out, overflow, last
//
// Binary, octal and hex store one digit per cycle, then emit the characters
// one per cycle from the digit store read port while out is not stalled;
// decimal first runs the bit-serial binary-to-BCD shifter. Unknown kinds
// give no output.
// Reset is synchronous; the output register parts the sides, so a stall on
// out only holds emission, and in is stalled until a run completes.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  kind,
  input  wire logic [i2a_pkg::VALUE_W-1:0] value,
  input  wire logic [i2a_pkg::CNT_W-1:0]   min_width,
  input  wire logic                        zero_pad,
  input  wire logic [i2a_pkg::SPACE_W-1:0] space_left,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       char_out,
  output logic                             overflow,
  output logic                             last
);
  import i2a_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  i2a_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  i2a_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .kind      (kind),
    .value     (value),
    .min_width (min_width),
    .zero_pad  (zero_pad),
    .space_left(space_left),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .overflow  (overflow),
    .last      (last)
  );

endmodule
`default_nettype wire

FILE: design/i2a_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module i2a_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/i2a_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_dp: formatter datapath
// Magnitude and BCD registers, digit store, counters and output word register.
// ----------------------------------------------------------------------------
module i2a_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire i2a_pkg::dp_cmd_t                cmd,
  output i2a_pkg::dp_stat_t                    st,
  input  wire logic [2:0]                      kind,
  input  wire logic [i2a_pkg::VALUE_W-1:0]     value,
  input  wire logic [i2a_pkg::CNT_W-1:0]       min_width,
  input  wire logic                            zero_pad,
  input  wire logic [i2a_pkg::SPACE_W-1:0]     space_left,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           char_out,
  output logic                                 overflow,
  output logic                                 last
);
  import i2a_pkg::*;

  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   bcd;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   dcnt;
  logic [CNT_W-1:0]   pad;
  logic [SPACE_W-1:0] space;
  logic [CNT_W-1:0]   mw;
  logic               neg;
  logic               zp;
  logic [2:0]         kind_r;

  logic               in_neg;
  logic [VALUE_W-1:0] in_mag;
  logic [MAG_W-1:0]   bcd_adj;
  logic [MAG_W-1:0]   mag_shr;
  logic [3:0]         digit;
  logic [CNT_W:0]     used;
  logic [CNT_W:0]     mw_ext;
  logic [CNT_W-1:0]   pad_calc;
  logic               ram_we;
  logic               ram_re;
  logic [DADDR_W-1:0] ram_raddr;
  logic [3:0]         ram_rdata;
  logic               out_free;
  logic [7:0]         ch;

  // Input magnitude and sign
  assign in_neg = (kind == KIND_SDEC) && value[VALUE_W-1];
  assign in_mag = in_neg ? (VALUE_W'(0) - value) : value;

  // Add-3 correction on every BCD digit
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // Digit and shifted magnitude per base
  always_comb begin
    unique case (kind_r)
      KIND_BIN: begin
        digit   = {3'd0, mag[0]};
        mag_shr = mag >> 1;
      end
      KIND_OCT: begin
        digit   = {1'b0, mag[2:0]};
        mag_shr = mag >> 3;
      end
      default: begin
        digit   = mag[3:0];
        mag_shr = mag >> 4;
      end
    endcase
  end

  // Pad count from digits, sign and saturated width
  assign used     = {1'b0, dcnt} + {{CNT_W{1'b0}}, neg};
  assign mw_ext   = {1'b0, mw};
  assign pad_calc = (mw_ext > used) ? CNT_W'(mw_ext - used) : '0;

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      dcnt  <= '0;
      pad   <= '0;
      space <= '0;
    end else begin
      if (cmd.load) begin
        mag    <= MAG_W'(in_mag);
        bcd    <= '0;
        step   <= '0;
        dcnt   <= '0;
        neg    <= in_neg;
        zp     <= zero_pad;
        kind_r <= kind;
        space  <= space_left;
        mw     <= (min_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : min_width;
      end
      if (cmd.dabble) begin
        bcd  <= {bcd_adj[MAG_W-2:0], mag[VALUE_W-1]};
        mag  <= {mag[MAG_W-1:VALUE_W], mag[VALUE_W-2:0], 1'b0};
        step <= step + 1'b1;
      end
      if (cmd.bcd_move) begin
        mag <= bcd;
      end
      if (cmd.extract) begin
        mag <= mag_shr;
        if (dcnt < CNT_W'(DIGIT_DEPTH)) begin
          dcnt <= dcnt + 1'b1;
        end
      end
      if (cmd.setup) begin
        pad <= pad_calc;
      end
      // Advance counters on each character that fits
      if (cmd.emit && (space != '0)) begin
        space <= space - 1'b1;
        if (cmd.sel == CH_PAD) begin
          pad <= pad - 1'b1;
        end
        if (cmd.sel == CH_DIGIT) begin
          dcnt <= dcnt - 1'b1;
        end
      end
    end
  end

  // Digit store
  assign ram_we    = cmd.extract && (dcnt < CNT_W'(DIGIT_DEPTH));
  assign ram_re    = cmd.setup || (cmd.emit && (cmd.sel == CH_DIGIT));
  assign ram_raddr = cmd.setup ? DADDR_W'(dcnt - 1'b1) : DADDR_W'(dcnt - 2'd2);

  i2a_ram #(
    .WIDTH(4),
    .DEPTH(DIGIT_DEPTH)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(dcnt[DADDR_W-1:0]),
    .wdata(digit),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Character select
  always_comb begin
    unique case (cmd.sel)
      CH_MINUS: ch = CHAR_MINUS;
      CH_PAD:   ch = zp ? CHAR_ZERO : CHAR_SPACE;
      CH_DIGIT: ch = digit_char(ram_rdata, kind_r == KIND_HEXU);
      default:  ch = '0;
    endcase
  end

  // Output word register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (space == '0) begin
        char_out <= '0;
        overflow <= 1'b1;
        last     <= 1'b1;
      end else begin
        char_out <= ch;
        overflow <= 1'b0;
        last     <= (cmd.sel == CH_DIGIT) && (dcnt == CNT_W'(1));
      end
    end
  end

  // Status to the controller
  always_comb begin
    st.in_kind_ok  = (kind <= KIND_HEXU);
    st.in_is_dec   = (kind == KIND_SDEC) || (kind == KIND_UDEC);
    st.dabble_last = (step == STEP_W'(DABBLE_STEPS - 1));
    st.mag_last    = (mag_shr == '0);
    st.neg         = neg;
    st.zp          = zp;
    st.pad_zero    = (pad == '0);
    st.dcnt_one    = (dcnt == CNT_W'(1));
    st.space_zero  = (space == '0);
    st.out_free    = out_free;
  end

  a_dcnt_range: assert property (@(posedge clk) disable iff (rst)
    dcnt <= CNT_W'(DIGIT_DEPTH))
    else $error("digit count beyond store depth");

  a_digit_avail: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.sel == CH_DIGIT)) |-> (dcnt != '0))
    else $error("digit emitted with empty store");

  a_space_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (space != '0)) |=> (space == $past(space) - 1'b1))
    else $error("space count did not advance");

endmodule
`default_nettype wire

FILE: design/i2a_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_ctrl: formatter controller
// Sequences load, BCD conversion, digit extraction and character emission.
// ----------------------------------------------------------------------------
module i2a_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire i2a_pkg::dp_stat_t st,
  output i2a_pkg::dp_cmd_t       cmd
);
  import i2a_pkg::*;

  state_t state;
  state_t state_next;
  logic   sign_pre;
  logic   sign_post;

  assign sign_pre  = st.neg && st.zp;
  assign sign_post = st.neg && !st.zp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && st.in_kind_ok) begin
          state_next = st.in_is_dec ? ST_DABBLE : ST_EXTRACT;
        end
      end
      ST_DABBLE: begin
        if (st.dabble_last) state_next = ST_MOVE;
      end
      ST_MOVE: state_next = ST_EXTRACT;
      ST_EXTRACT: begin
        if (st.mag_last) state_next = ST_SETUP;
      end
      ST_SETUP: state_next = ST_SIGN_PRE;
      ST_SIGN_PRE: begin
        if (!sign_pre) begin
          state_next = ST_PAD;
        end else if (st.out_free) begin
          state_next = st.space_zero ? ST_IDLE : ST_PAD;
        end
      end
      ST_PAD: begin
        if (st.pad_zero) begin
          state_next = ST_SIGN_POST;
        end else if (st.out_free && st.space_zero) begin
          state_next = ST_IDLE;
        end
      end
      ST_SIGN_POST: begin
        if (!sign_post) begin
          state_next = ST_DIGITS;
        end else if (st.out_free) begin
          state_next = st.space_zero ? ST_IDLE : ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (st.out_free && (st.space_zero || st.dcnt_one)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.sel  = CH_MINUS;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DABBLE:  cmd.dabble   = 1'b1;
      ST_MOVE:    cmd.bcd_move = 1'b1;
      ST_EXTRACT: cmd.extract  = 1'b1;
      ST_SETUP:   cmd.setup    = 1'b1;
      ST_SIGN_PRE: begin
        cmd.emit = sign_pre && st.out_free;
        cmd.sel  = CH_MINUS;
      end
      ST_PAD: begin
        cmd.emit = !st.pad_zero && st.out_free;
        cmd.sel  = CH_PAD;
      end
      ST_SIGN_POST: begin
        cmd.emit = sign_post && st.out_free;
        cmd.sel  = CH_MINUS;
      end
      ST_DIGITS: begin
        cmd.emit = st.out_free;
        cmd.sel  = CH_DIGIT;
      end
      default: cmd = '0;
    endcase
  end

  a_ovf_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && st.space_zero) |=> (state == ST_IDLE))
    else $error("run continued after overflow word");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("word emitted into a full output register");

  a_dabble_done: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DABBLE) && st.dabble_last) |=> (state == ST_MOVE))
    else $error("BCD conversion did not finish in place");

endmodule
`default_nettype wire

FILE: bench/integer_to_ascii_formatter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_test: self-checking bench of the formatter
// Walks a directed table of conversions (extremes, every kind, sign and pad
// placement, width saturation, space exhaustion), then random words under
// random idling on both sides. Every emitted character is checked against a
// scoreboard fed by a behavioral formatter, or by typed-in text for the
// rows whose output is obvious.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core_test;
  import i2a_pkg::*;

  localparam int RAND_WORDS = 186;
  localparam int QUIET_FROM = 160;
  localparam int PAUSE_AT   = 90;
  localparam int HOLD_LEN   = 500;
  localparam int TAIL_LEN   = 200;
  localparam int IDLE_LIMIT = 4000;

  localparam logic [127:0] LOWER_GLYPHS = "0123456789abcdef";
  localparam logic [127:0] UPPER_GLYPHS = "0123456789ABCDEF";

  typedef struct packed {
    logic [2:0]         kind;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   min_width;
    logic               zero_pad;
    logic [SPACE_W-1:0] space_left;
  } conv_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       overflow;
    logic       last;
  } char_word_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         kind;
  logic [VALUE_W-1:0] value;
  logic [CNT_W-1:0]   min_width;
  logic               zero_pad;
  logic [SPACE_W-1:0] space_left;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         char_out;
  logic               overflow;
  logic               last;

  // Directed table: stimulus plus optional typed-in text
  conv_word_t dir_words[$];
  bit         dir_typed[$];
  bit         dir_ovf[$];
  string      dir_text[$];

  // Table index per offered word, -1 for random words, which the formatter checks
  int         offered_rows[$];
  char_word_t expected_chars[$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  integer_to_ascii_formatter_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .min_width  (min_width),
    .zero_pad   (zero_pad),
    .space_left (space_left),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_out   (char_out),
    .overflow   (overflow),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Build the expected character stream of one conversion
  function automatic void format_word(input conv_word_t w);
    logic [63:0]  mag;
    logic [63:0]  base;
    logic [3:0]   dig [0:63];
    logic [7:0]   field [0:127];
    logic [127:0] glyphs;
    int           ndig;
    int           nfield;
    int           width;
    int           pads;
    int           space;
    bit           neg;
    char_word_t   cw;
    case (w.kind)
      KIND_BIN: base = 64'd2;
      KIND_SDEC, KIND_UDEC: base = 64'd10;
      KIND_OCT: base = 64'd8;
      KIND_HEXL, KIND_HEXU: base = 64'd16;
      default: return;
    endcase
    neg = (w.kind == KIND_SDEC) && w.value[63];
    mag = neg ? -w.value : w.value;
    glyphs = (w.kind == KIND_HEXU) ? UPPER_GLYPHS : LOWER_GLYPHS;
    // Split the magnitude into digits, least significant first
    ndig = 0;
    do begin
      if (ndig < DIGIT_DEPTH) begin
        dig[ndig] = 4'(mag % base);
        ndig++;
      end
      mag = mag / base;
    end while (mag != 64'd0);
    width = (w.min_width > MAX_WIDTH) ? MAX_WIDTH : int'(w.min_width);
    pads = (width > ndig + int'(neg)) ? width - ndig - int'(neg) : 0;
    // Lay out sign, padding and digits
    nfield = 0;
    if (neg && w.zero_pad) begin
      field[nfield] = CHAR_MINUS;
      nfield++;
    end
    repeat (pads) begin
      field[nfield] = w.zero_pad ? CHAR_ZERO : CHAR_SPACE;
      nfield++;
    end
    if (neg && !w.zero_pad) begin
      field[nfield] = CHAR_MINUS;
      nfield++;
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      field[nfield] = glyphs[8 * (15 - dig[i]) +: 8];
      nfield++;
    end
    // Emit while buffer space lasts, then end with an overflow word
    space = int'(w.space_left);
    for (int i = 0; i < nfield; i++) begin
      if (space == 0) begin
        cw = '{8'h00, 1'b1, 1'b1};
        expected_chars.push_back(cw);
        return;
      end
      cw = '{field[i], 1'b0, i == nfield - 1};
      expected_chars.push_back(cw);
      space--;
    end
  endfunction

  task automatic add_row(input logic [2:0] k, input logic [63:0] v, input logic [6:0] mw,
                         input logic zp, input logic [7:0] sp, input bit typed,
                         input bit ovf, input string text);
    conv_word_t w;
    w = '{k, v, mw, zp, sp};
    dir_words.push_back(w);
    dir_typed.push_back(typed);
    dir_ovf.push_back(ovf);
    dir_text.push_back(text);
  endtask

  // Offer one word, optionally after an idle burst, and wait for acceptance
  task automatic send_word(input conv_word_t w, input int row);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    offered_rows.push_back(row);
    in_valid   <= 1'b1;
    kind       <= w.kind;
    value      <= w.value;
    min_width  <= w.min_width;
    zero_pad   <= w.zero_pad;
    space_left <= w.space_left;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Scoreboard: predict on input words, check output words, watch for hangs
  always @(posedge clk) begin : scoreboard
    int         row;
    int         len;
    bit         moved;
    conv_word_t got_in;
    char_word_t want;
    char_word_t cw;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        row = offered_rows.pop_front();
        if (row >= 0 && dir_typed[row]) begin
          len = dir_text[row].len();
          for (int i = 0; i < len; i++) begin
            cw = '{dir_text[row][i], 1'b0, (i == len - 1) && !dir_ovf[row]};
            expected_chars.push_back(cw);
          end
          if (dir_ovf[row]) begin
            cw = '{8'h00, 1'b1, 1'b1};
            expected_chars.push_back(cw);
          end
        end else begin
          got_in = '{kind, value, min_width, zero_pad, space_left};
          format_word(got_in);
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_chars.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: char=%h overflow=%b last=%b",
                     char_out, overflow, last);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          // char_out carries no meaning on an overflow word
          if (overflow !== want.overflow || last !== want.last ||
              (!want.overflow && char_out !== want.ch)) begin
            if (mismatches < 10)
              $display({"mismatch: expected char=%h overflow=%b last=%b, ",
                        "got char=%h overflow=%b last=%b"},
                       want.ch, want.overflow, want.last, char_out, overflow, last);
            mismatches++;
          end
        end
      end
      // Count cycles with no accepted word
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end
  initial begin : receiver
    int burst;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        burst = $urandom_range(1, 15);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (burst) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    conv_word_t w;
    int         counted;
    bit         paused;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    kind       <= '0;
    value      <= '0;
    min_width  <= '0;
    zero_pad   <= 1'b0;
    space_left <= '0;

    // kind, value, min_width, zero_pad, space_left, typed, overflow, text
    add_row(KIND_BIN,  64'd0,                  7'd0,   1'b0, 8'd255, 1, 0, "0");
    add_row(KIND_SDEC, 64'd0,                  7'd0,   1'b0, 8'd255, 1, 0, "0");
    add_row(KIND_UDEC, 64'hFFFFFFFFFFFFFFFF,   7'd0,   1'b0, 8'd255, 1, 0,
            "18446744073709551615");
    add_row(KIND_SDEC, 64'hFFFFFFFFFFFFFFFF,   7'd0,   1'b0, 8'd255, 1, 0, "-1");
    add_row(KIND_SDEC, 64'h8000000000000000,   7'd0,   1'b0, 8'd255, 1, 0,
            "-9223372036854775808");
    add_row(KIND_SDEC, 64'h7FFFFFFFFFFFFFFF,   7'd0,   1'b0, 8'd255, 1, 0,
            "9223372036854775807");
    add_row(KIND_OCT,  64'hFFFFFFFFFFFFFFFF,   7'd0,   1'b0, 8'd255, 1, 0,
            "1777777777777777777777");
    add_row(KIND_HEXL, 64'hDEADBEEFCAFEF00D,   7'd0,   1'b0, 8'd255, 1, 0,
            "deadbeefcafef00d");
    add_row(KIND_HEXU, 64'hDEADBEEFCAFEF00D,   7'd0,   1'b0, 8'd255, 1, 0,
            "DEADBEEFCAFEF00D");
    add_row(3'd6,      64'd123,                7'd10,  1'b1, 8'd255, 1, 0, "");
    add_row(3'd7,      64'hFFFFFFFFFFFFFFFF,   7'd127, 1'b0, 8'd0,   1, 0, "");
    add_row(KIND_SDEC, -64'sd5,                7'd6,   1'b0, 8'd255, 1, 0, "    -5");
    add_row(KIND_SDEC, -64'sd5,                7'd6,   1'b1, 8'd255, 1, 0, "-00005");
    add_row(KIND_UDEC, 64'd12345,              7'd3,   1'b0, 8'd255, 1, 0, "12345");
    add_row(KIND_UDEC, 64'd7,                  7'd0,   1'b0, 8'd0,   1, 1, "");
    add_row(KIND_UDEC, 64'd12345,              7'd0,   1'b0, 8'd3,   1, 1, "123");
    add_row(KIND_SDEC, -64'sd5,                7'd6,   1'b1, 8'd1,   1, 1, "-");
    add_row(KIND_UDEC, 64'd42,                 7'd0,   1'b0, 8'd2,   1, 0, "42");
    add_row(KIND_BIN,  64'd5,                  7'd8,   1'b0, 8'd4,   1, 1, "    ");
    add_row(KIND_HEXU, 64'd0,                  7'd1,   1'b1, 8'd255, 1, 0, "0");
    add_row(KIND_OCT,  64'd8,                  7'd0,   1'b0, 8'd255, 1, 0, "10");
    // Width saturation and full-length binary
    add_row(KIND_BIN,  64'hFFFFFFFFFFFFFFFF,   7'd64,  1'b0, 8'd255, 0, 0, "");
    add_row(KIND_BIN,  64'h8000000000000000,   7'd0,   1'b1, 8'd64,  0, 0, "");
    add_row(KIND_HEXL, 64'hFF,                 7'd127, 1'b1, 8'd255, 0, 0, "");
    add_row(KIND_SDEC, 64'h8000000000000000,   7'd100, 1'b0, 8'd70,  0, 0, "");

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_words.size(); i++) send_word(dir_words[i], i);

    // Hold the receiver off while the sender keeps offering
    hold_req = 1'b1;
    counted = 0;
    paused = 1'b0;
    while (counted < RAND_WORDS) begin
      // Drain the block once in the middle of the run
      if (counted == PAUSE_AT && !paused) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk);
        while (expected_chars.size() != 0 || offered_rows.size() != 0);
      end
      quiet = (counted >= QUIET_FROM);
      w.kind = ($urandom_range(0, 19) < 18) ? 3'($urandom_range(0, 5))
                                           : 3'($urandom_range(6, 7));
      case ($urandom_range(0, 5))
        0: w.value = 64'($urandom_range(0, 20));
        1: w.value = {$urandom, $urandom};
        2: w.value = {32'd0, $urandom};
        3: w.value = -64'($urandom_range(1, 1000));
        4: w.value = ($urandom_range(0, 1) == 0) ? 64'h8000000000000000
                                                 : 64'hFFFFFFFFFFFFFFFF;
        default: w.value = 64'd1 << $urandom_range(0, 63);
      endcase
      w.min_width = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 24));
      w.zero_pad = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0)
        w.space_left = 8'($urandom_range(0, 30));
      else
        w.space_left = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(64, 255));
      send_word(w, -1);
      counted++;
    end
    in_valid <= 1'b0;

    // Drain, then let the block settle before judging
    do @(posedge clk);
    while (expected_chars.size() != 0 || offered_rows.size() != 0);
    repeat (TAIL_LEN) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
